// File: design/tscd_pkg.sv
// ----------------------------------------------------------------------------
// tscd_pkg - shared types, constants and CRC step for the scratchpad decoder
// Field widths, frame positions, CRC-8 byte update and the scaling constants.
// ----------------------------------------------------------------------------
`default_nettype none

package tscd_pkg;

    localparam int DATA_W  = 8;
    localparam int POS_W   = 4;
    localparam int RAW_W   = 16;
    localparam int MILLI_W = 22;
    localparam int CENTI_W = 19;

    // raw * 1000 stays below 2^25 in magnitude
    localparam int PROD_W  = 26;
    localparam int DIV16_SHIFT = 4;

    // divide by ten through a reciprocal: exact for operands below 2^22
    localparam int MAG_W       = 22;
    localparam int RECIP_W     = 20;
    localparam int RECIP_SHIFT = 23;
    localparam int RECIP_PROD_W = MAG_W + RECIP_W;

    localparam logic [RECIP_W-1:0] RECIP_TEN   = 20'd838861;
    localparam logic [PROD_W-1:0]  SCALE_MILLI = 26'd1000;
    localparam logic [PROD_W-1:0]  TRUNC_BIAS  = 26'd15;
    localparam logic [MAG_W-1:0]   ROUND_HALF  = 22'd5;

    localparam logic [DATA_W-1:0] CRC_POLY = 8'h8C;
    localparam logic [DATA_W-1:0] CRC_INIT = 8'h00;

    localparam logic [POS_W-1:0] POS_FIRST = 4'd0;
    localparam logic [POS_W-1:0] POS_HIGH  = 4'd1;
    localparam logic [POS_W-1:0] POS_LAST  = 4'd8;
    localparam logic [POS_W-1:0] POS_DONE  = 4'd9;

    typedef enum logic {
        STATUS_OK      = 1'b0,
        STATUS_CRC_ERR = 1'b1
    } status_t;

    // reflected CRC-8, one byte, LSB first
    function automatic logic [DATA_W-1:0] crc_byte(
        input logic [DATA_W-1:0] crc_in,
        input logic [DATA_W-1:0] data_in
    );
        logic [DATA_W-1:0] crc;
        logic [DATA_W-1:0] dat;
        logic              mix;
        crc = crc_in;
        dat = data_in;
        for (int k = 0; k < DATA_W; k++) begin
            mix = crc[0] ^ dat[0];
            crc = crc >> 1;
            if (mix) begin
                crc = crc ^ CRC_POLY;
            end
            dat = dat >> 1;
        end
        return crc;
    endfunction

endpackage

`default_nettype wire

// File: design/temp_scratchpad_crc_decode.sv
// ----------------------------------------------------------------------------
// temp_scratchpad_crc_decode - scratchpad CRC check and temperature decode
// Frames the 9-byte scratchpad, checks CRC-8 over bytes 0..7 against byte 8
// and converts the raw reading to milli- and centi-degrees.
// ----------------------------------------------------------------------------
// Path: byte 8 is registered through the frame stage, the x1000/16 stage and
//   the /10 rounding stage, in order, to m_valid; output back-pressure can hold it.
// Throughput: one byte per cycle; the per-byte CRC update is a single
//   combinational byte step. Any byte stalls only while all three result
//   stages are full and m_ready is low.
// Reset: synchronous, active low; clears CRC, framing position, raw bytes
//   and all stage valids. No clearing pass.
`default_nettype none

module temp_scratchpad_crc_decode (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // input request channel
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic [tscd_pkg::DATA_W-1:0]        s_data_byte,
    input  wire logic                               s_first_byte,
    // result request channel
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic                                    m_status,
    output logic signed [tscd_pkg::MILLI_W-1:0]     m_temp_milli,
    output logic signed [tscd_pkg::CENTI_W-1:0]     m_temp_cdeg
);
    import tscd_pkg::*;

    // ---------------------------------------------------------------- framing
    logic [DATA_W-1:0] crc_reg,  crc_next;
    logic [POS_W-1:0]  pos_reg,  pos_next;
    logic [DATA_W-1:0] low_reg,  low_next;
    logic [DATA_W-1:0] high_reg, high_next;

    // stage 1: raw reading and status of a finished frame
    logic              v1_reg,   v1_next;
    logic [RAW_W-1:0]  raw1_reg, raw1_next;
    status_t           st1_reg,  st1_next;

    // stage 2: milli-degrees
    logic                      v2_reg,    v2_next;
    logic signed [MILLI_W-1:0] milli2_reg, milli2_next;
    status_t                   st2_reg,   st2_next;

    // output register
    logic                      vo_reg,    vo_next;
    logic signed [MILLI_W-1:0] milli_o_reg, milli_o_next;
    logic signed [CENTI_W-1:0] centi_o_reg, centi_o_next;
    status_t                   st_o_reg,  st_o_next;

    // per-stage ready: a stage takes a request when empty or draining
    logic rdy_o, rdy2, rdy1;
    assign rdy_o   = !vo_reg || m_ready;
    assign rdy2    = !v2_reg || rdy_o;
    assign rdy1    = !v1_reg || rdy2;
    assign s_ready = rdy1;

    logic              s_take;
    logic [POS_W-1:0]  pos_cur;
    logic [DATA_W-1:0] crc_cur;
    logic              frame_end;

    assign s_take  = s_valid && s_ready;
    // a first flag restarts the frame before this byte is placed
    assign pos_cur = s_first_byte ? POS_FIRST : pos_reg;
    assign crc_cur = s_first_byte ? CRC_INIT : crc_reg;
    assign frame_end = s_take && (pos_cur == POS_LAST);

    always_comb begin
        crc_next  = crc_reg;
        pos_next  = pos_reg;
        low_next  = low_reg;
        high_next = high_reg;
        if (s_take) begin
            if (pos_cur < POS_LAST) begin
                crc_next = crc_byte(crc_cur, s_data_byte);
                pos_next = pos_cur + POS_W'(1);
                if (pos_cur == POS_FIRST) begin
                    low_next = s_data_byte;
                end else if (pos_cur == POS_HIGH) begin
                    high_next = s_data_byte;
                end
            end else if (pos_cur == POS_LAST) begin
                pos_next = POS_DONE;
            end
            // positions beyond the last byte: ignored, state kept
        end
    end

    // ---------------------------------------------------------------- stage 1
    always_comb begin
        v1_next   = v1_reg;
        raw1_next = raw1_reg;
        st1_next  = st1_reg;
        if (rdy1) begin
            v1_next = frame_end;
            if (frame_end) begin
                // mismatch: zero reading gives zero milli and centi
                if (crc_cur == s_data_byte) begin
                    raw1_next = {high_reg, low_reg};
                    st1_next  = STATUS_OK;
                end else begin
                    raw1_next = '0;
                    st1_next  = STATUS_CRC_ERR;
                end
            end
        end
    end

    // ---------------------------------------------------------------- stage 2
    logic signed [PROD_W-1:0] prod1;
    logic signed [PROD_W-1:0] biased1;

    assign prod1   = PROD_W'($signed(raw1_reg)) * $signed(SCALE_MILLI);
    // truncate toward zero: bias negatives before the arithmetic shift
    assign biased1 = prod1[PROD_W-1] ? (prod1 + $signed(TRUNC_BIAS)) : prod1;

    always_comb begin
        v2_next     = v2_reg;
        milli2_next = milli2_reg;
        st2_next    = st2_reg;
        if (rdy2) begin
            v2_next = v1_reg;
            if (v1_reg) begin
                milli2_next = biased1[DIV16_SHIFT +: MILLI_W];
                st2_next    = st1_reg;
            end
        end
    end

    // ---------------------------------------------------------------- stage 3
    logic                      neg2;
    logic [MAG_W-1:0]          mag2;
    logic [MAG_W-1:0]          half_up2;
    logic [RECIP_PROD_W-1:0]   recip_prod2;
    logic [CENTI_W-1:0]        quot2;

    assign neg2        = milli2_reg[MILLI_W-1];
    assign mag2        = neg2 ? MAG_W'(-milli2_reg) : MAG_W'(milli2_reg);
    // round half away from zero on the magnitude
    assign half_up2    = mag2 + ROUND_HALF;
    assign recip_prod2 = RECIP_PROD_W'(half_up2) * RECIP_PROD_W'(RECIP_TEN);
    assign quot2       = recip_prod2[RECIP_SHIFT +: CENTI_W];

    always_comb begin
        vo_next      = vo_reg;
        milli_o_next = milli_o_reg;
        centi_o_next = centi_o_reg;
        st_o_next    = st_o_reg;
        if (rdy_o) begin
            vo_next = v2_reg;
            if (v2_reg) begin
                milli_o_next = milli2_reg;
                centi_o_next = neg2 ? $signed(-quot2) : $signed(quot2);
                st_o_next    = st2_reg;
            end
        end
    end

    // ---------------------------------------------------------------- registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg  <= CRC_INIT;
            pos_reg  <= POS_FIRST;
            low_reg  <= '0;
            high_reg <= '0;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            vo_reg   <= 1'b0;
        end else begin
            crc_reg  <= crc_next;
            pos_reg  <= pos_next;
            low_reg  <= low_next;
            high_reg <= high_next;
            v1_reg   <= v1_next;
            v2_reg   <= v2_next;
            vo_reg   <= vo_next;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        raw1_reg    <= raw1_next;
        st1_reg     <= st1_next;
        milli2_reg  <= milli2_next;
        st2_reg     <= st2_next;
        milli_o_reg <= milli_o_next;
        centi_o_reg <= centi_o_next;
        st_o_reg    <= st_o_next;
    end

    assign m_valid      = vo_reg;
    assign m_status     = st_o_reg;
    assign m_temp_milli = milli_o_reg;
    assign m_temp_cdeg  = centi_o_reg;

endmodule

`default_nettype wire

// File: design/tscd_checker.sv
// ----------------------------------------------------------------------------
// tscd_checker - port-level checks for temp_scratchpad_crc_decode
// Result channel behaviour and consistency of the decoded fields.
// ----------------------------------------------------------------------------
`default_nettype none

module tscd_checker (
    input wire logic                                aclk,
    input wire logic                                aresetn,
    input wire logic                                s_ready,
    input wire logic                                m_valid,
    input wire logic                                m_ready,
    input wire logic                                m_status,
    input wire logic signed [tscd_pkg::MILLI_W-1:0] m_temp_milli,
    input wire logic signed [tscd_pkg::CENTI_W-1:0] m_temp_cdeg
);
    import tscd_pkg::*;

    // nothing pending straight after reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status)
            && $stable(m_temp_milli) && $stable(m_temp_cdeg))
        else $error("stalled result changed");

    // CRC error carries zero temperatures
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == STATUS_CRC_ERR) |->
            (m_temp_milli == '0) && (m_temp_cdeg == '0))
        else $error("error result with non-zero temperature");

    // centi follows the sign of milli
    a_sign: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_temp_milli[MILLI_W-1] == m_temp_cdeg[CENTI_W-1])
            || (m_temp_cdeg == '0))
        else $error("centi sign disagrees with milli");

    // the input side never holds off while the whole pipeline is empty
    a_ready_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid && $past(!m_valid) && $past(!m_valid, 2) && $past(!m_valid, 3)
            && $past(aresetn, 3) |-> s_ready)
        else $error("input not ready with empty pipeline");

endmodule

bind temp_scratchpad_crc_decode tscd_checker u_tscd_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_status     (m_status),
    .m_temp_milli (m_temp_milli),
    .m_temp_cdeg  (m_temp_cdeg)
);

`default_nettype wire

// File: verif/temp_scratchpad_crc_decode_test.sv
// ----------------------------------------------------------------------------
// temp_scratchpad_crc_decode_test - self-checking bench for the scratchpad decoder
// Feeds framed 9-byte scratchpads, broken frames and loose bytes through the
// input channel under random idling and back-pressure. A scoreboard predicts
// each CRC verdict and temperature reading and checks every result in order.
// ----------------------------------------------------------------------------
`default_nettype none

typedef struct {
    tscd_pkg::status_t                      status;
    logic signed [tscd_pkg::MILLI_W-1:0]    milli;
    logic signed [tscd_pkg::CENTI_W-1:0]    centi;
} reading_t;

class scratchpad_scoreboard;
    localparam int MAX_REPORTS = 40;

    reading_t                     readings_due[$];
    logic [tscd_pkg::DATA_W-1:0]  crc_acc;
    logic [tscd_pkg::POS_W-1:0]   frame_pos;
    logic [tscd_pkg::DATA_W-1:0]  raw_lo;
    logic [tscd_pkg::DATA_W-1:0]  raw_hi;
    int                           errors;
    int                           good_frames;
    int                           bad_frames;
    int                           bytes_taken;

    function new();
        crc_acc     = tscd_pkg::CRC_INIT;
        frame_pos   = tscd_pkg::POS_FIRST;
        raw_lo      = '0;
        raw_hi      = '0;
        errors      = 0;
        good_frames = 0;
        bad_frames  = 0;
        bytes_taken = 0;
    endfunction

    // reflected CRC-8, data bits taken LSB first
    function logic [7:0] crc_update(logic [7:0] crc, logic [7:0] b);
        for (int i = 0; i < 8; i++) begin
            if (crc[0] ^ b[i]) begin
                crc = (crc >> 1) ^ tscd_pkg::CRC_POLY;
            end else begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

    function int pending();
        return readings_due.size();
    endfunction

    function void note_byte(logic [7:0] b, logic first);
        reading_t           r;
        logic signed [15:0] raw;
        int                 milli;
        int                 centi;
        bytes_taken++;
        if (first) begin
            crc_acc   = tscd_pkg::CRC_INIT;
            frame_pos = tscd_pkg::POS_FIRST;
        end
        if (frame_pos > tscd_pkg::POS_LAST) begin
            return;
        end
        if (frame_pos < tscd_pkg::POS_LAST) begin
            crc_acc = crc_update(crc_acc, b);
            if (frame_pos == tscd_pkg::POS_FIRST) begin
                raw_lo = b;
            end else if (frame_pos == tscd_pkg::POS_HIGH) begin
                raw_hi = b;
            end
            frame_pos++;
            return;
        end
        frame_pos = tscd_pkg::POS_DONE;
        milli = 0;
        centi = 0;
        if (crc_acc == b) begin
            raw   = {raw_hi, raw_lo};
            milli = (int'(raw) * 1000) / 16;
            centi = (milli >= 0) ? (milli + 5) / 10 : (milli - 5) / 10;
            r.status = tscd_pkg::STATUS_OK;
            good_frames++;
        end else begin
            r.status = tscd_pkg::STATUS_CRC_ERR;
            bad_frames++;
        end
        r.milli = milli[tscd_pkg::MILLI_W-1:0];
        r.centi = centi[tscd_pkg::CENTI_W-1:0];
        readings_due.push_back(r);
    endfunction

    function void check_reading(logic status, logic signed [tscd_pkg::MILLI_W-1:0] milli,
                                logic signed [tscd_pkg::CENTI_W-1:0] centi);
        reading_t due;
        if (readings_due.size() == 0) begin
            errors++;
            if (errors < MAX_REPORTS) $error("result with nothing outstanding");
            return;
        end
        due = readings_due.pop_front();
        if (status !== due.status) begin
            errors++;
            if (errors < MAX_REPORTS)
                $error("status: expected %0d, got %0d", due.status, status);
        end
        if (milli !== due.milli) begin
            errors++;
            if (errors < MAX_REPORTS)
                $error("temp_milli: expected %0d, got %0d", due.milli, milli);
        end
        if (centi !== due.centi) begin
            errors++;
            if (errors < MAX_REPORTS)
                $error("temp_cdeg: expected %0d, got %0d", due.centi, centi);
        end
    endfunction
endclass

module temp_scratchpad_crc_decode_test;

    import tscd_pkg::*;

    localparam int RANDOM_BYTES = 1100;
    localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
    localparam int CYCLE_LIMIT  = 400000;
    localparam int TAIL_CYCLES  = 16;    // pipeline is 3 deep

    typedef enum int {
        RX_ALWAYS,
        RX_MOSTLY,
        RX_RARELY,
        RX_STUCK
    } rx_mode_t;

    // every input starts at a known value
    logic                       aclk         = 1'b0;
    logic                       aresetn      = 1'b0;
    logic                       s_valid      = 1'b0;
    logic [DATA_W-1:0]          s_data_byte  = '0;
    logic                       s_first_byte = 1'b0;
    logic                       m_ready      = 1'b0;
    logic                       s_ready;
    logic                       m_valid;
    logic                       m_status;
    logic signed [MILLI_W-1:0]  m_temp_milli;
    logic signed [CENTI_W-1:0]  m_temp_cdeg;

    scratchpad_scoreboard sb = new();

    int  cycle_count = 0;
    int  burst_left  = 0;
    bit  gaps_off    = 1'b0;
    bit  hold_req    = 1'b0;
    int  hold_left   = 0;
    int  rx_run      = 0;
    rx_mode_t rx_mode = RX_ALWAYS;

    temp_scratchpad_crc_decode dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data_byte  (s_data_byte),
        .s_first_byte (s_first_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_temp_milli (m_temp_milli),
        .m_temp_cdeg  (m_temp_cdeg)
    );

    always #2 aclk = ~aclk;

    // watchdog: a hung block or a lost result ends the run here
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[temp_scratchpad_crc_decode] ERROR");
            $finish;
        end
    end

    // result monitor: values read straight after the edge are the pre-edge ones,
    // since the block and the drivers only change through nonblocking updates
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_reading(m_status, m_temp_milli, m_temp_cdeg);
        end
    end

    // receiver: random stall pattern of its own, plus one long hold-off on request
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES - 1;
                m_ready  <= 1'b0;
            end else begin
                if (rx_run == 0) begin
                    rx_mode = rx_mode_t'($urandom_range(0, 3));
                    rx_run  = $urandom_range(1, 40);
                end
                rx_run--;
                case (rx_mode)
                    RX_ALWAYS: m_ready <= 1'b1;
                    RX_MOSTLY: m_ready <= ($urandom_range(0, 3) != 0);
                    RX_RARELY: m_ready <= ($urandom_range(0, 3) == 0);
                    default:   m_ready <= 1'b0;
                endcase
            end
        end
    end

    // Offer one byte request and hold it until taken. Valid stays high into the
    // next request unless a gap starts here, so each step sees one update only.
    task automatic push_byte(input logic [DATA_W-1:0] d, input logic f);
        s_valid      <= 1'b1;
        s_data_byte  <= d;
        s_first_byte <= f;
        do @(posedge aclk); while (s_ready !== 1'b1);
        sb.note_byte(d, f);
        if (!gaps_off) begin
            if (burst_left == 0) begin
                burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                         : $urandom_range(1, 12);
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end else begin
                burst_left--;
            end
        end
    endtask

    // Build a scratchpad around a raw reading; the check byte is the true CRC
    // unless corrupted. Only the first 'keep' bytes go out.
    task automatic send_frame(input logic [15:0] raw, input bit flagged,
                              input bit corrupt, input int keep);
        logic [DATA_W-1:0] fb [9];
        logic [DATA_W-1:0] crc;
        fb[0] = raw[7:0];
        fb[1] = raw[15:8];
        for (int i = 2; i < 8; i++) fb[i] = 8'($urandom_range(0, 255));
        crc = CRC_INIT;
        for (int i = 0; i < 8; i++) crc = sb.crc_update(crc, fb[i]);
        fb[8] = corrupt ? crc ^ 8'($urandom_range(1, 255)) : crc;
        for (int i = 0; i < keep; i++) push_byte(fb[i], flagged && (i == 0));
    endtask

    function automatic logic [15:0] pick_raw();
        logic [15:0] corners [12] = '{16'h0000, 16'h0001, 16'hFFFF, 16'h0002,
                                      16'hFFFE, 16'h7FFF, 16'h8000, 16'h0008,
                                      16'hFFF8, 16'h0550, 16'hFC90, 16'h0003};
        if ($urandom_range(0, 1) == 0) return 16'($urandom_range(0, 65535));
        return corners[$urandom_range(0, 11)];
    endfunction

    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    initial begin
        int  kind;
        bit  held;
        bit  paused;

        held   = 1'b0;
        paused = 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // --- directed ---
        // position 0 is framed out of reset: no first flag, most negative raw
        send_frame(16'h8000, 1'b0, 1'b0, 9);
        // stray byte after the check byte: ignored
        push_byte(8'hA5, 1'b0);
        // one byte of a frame, then a first flag restarts framing mid-frame
        send_frame(16'h0002, 1'b1, 1'b0, 1);
        send_frame(16'h7FFF, 1'b1, 1'b0, 9);
        // CRC mismatch: zero temperatures expected
        send_frame(16'hFFFE, 1'b1, 1'b1, 9);

        // --- random ---
        while (sb.bytes_taken < RANDOM_BYTES) begin
            if (!held && sb.bytes_taken > 300) begin
                // receiver holds off while back-to-back frames fill the block
                held     = 1'b1;
                gaps_off = 1'b1;
                hold_req = 1'b1;
                repeat (12) send_frame(pick_raw(), 1'b1, $urandom_range(0, 3) == 0, 9);
                gaps_off = 1'b0;
            end
            if (!paused && sb.bytes_taken > 700) begin
                paused = 1'b1;
                drain();
                repeat ($urandom_range(1, 10)) @(posedge aclk);
            end
            kind = $urandom_range(0, 99);
            if (kind < 70) begin
                send_frame(pick_raw(), 1'b1, $urandom_range(0, 3) == 0, 9);
            end else if (kind < 78) begin
                send_frame(pick_raw(), 1'b0, $urandom_range(0, 3) == 0, 9);
            end else if (kind < 86) begin
                send_frame(pick_raw(), 1'b1, 1'b0, $urandom_range(1, 8));
            end else if (kind < 94) begin
                repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(0, 255)), 1'b0);
            end else begin
                push_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Covered %0d bytes: %0d good-CRC and %0d bad-CRC scratchpads,",
                 sb.bytes_taken, sb.good_frames, sb.bad_frames);
        $display("with restarts, truncated frames, unflagged and trailing bytes.");
        if (sb.errors == 0) begin
            $display("[temp_scratchpad_crc_decode] OK");
        end else begin
            $display("[temp_scratchpad_crc_decode] ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
